// ===== rtl/core/bre_pkg.sv =====
// ---------------------------------------------------------------------------
// Ellipse rasterizer package
// Shared constants, operation codes and control structs of the rasterizer.
// ---------------------------------------------------------------------------
package bre_pkg;

   localparam int COORD_WIDTH_DEF  = 16;
   localparam int RADIUS_WIDTH_DEF = 12;
   localparam int COLOR_BITS       = 24;

   // Request kinds carried in req_tuser.
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Bit positions in rsp_tuser.
   localparam int RSP_USER_PIXEL    = 0;
   localparam int RSP_USER_FINISHED = 1;
   localparam int RSP_USER_BITS     = 2;

   // Engine status seen by the request side.
   typedef struct packed {
      logic busy;    // initial product of a start pending, state not yet usable
      logic active;  // a drawing is in progress
   } bre_status_type;

   // Control bits of one step handed to the result serializer.
   typedef struct packed {
      logic pixel;     // step carries four pixels, otherwise one idle result
      logic finished;  // drawing is complete after this step
   } bre_point_ctrl_type;

endpackage

// ===== rtl/core/bre_engine.sv =====
// ---------------------------------------------------------------------------
// Ellipse rasterizer engine
// Holds the drawing state and applies the Bresenham error update, one step
// per load. Products of the error terms are kept incrementally, so a step
// needs only adds; a start computes the initial product in its busy state.
// ---------------------------------------------------------------------------
module bre_engine #(
   parameter int COORD_WIDTH  = bre_pkg::COORD_WIDTH_DEF,
   parameter int RADIUS_WIDTH = bre_pkg::RADIUS_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start_load,
   input  logic                             step_load,
   input  logic signed [COORD_WIDTH-1:0]    center_x,
   input  logic signed [COORD_WIDTH-1:0]    center_y,
   input  logic [RADIUS_WIDTH-1:0]          radius_a,
   input  logic [RADIUS_WIDTH-1:0]          radius_b,
   input  logic [bre_pkg::COLOR_BITS-1:0]   pixel_color,
   output bre_pkg::bre_status_type          status,
   output bre_pkg::bre_point_ctrl_type      point_ctrl,
   output logic [COORD_WIDTH-1:0]           x_plus,
   output logic [COORD_WIDTH-1:0]           x_minus,
   output logic [COORD_WIDTH-1:0]           y_plus,
   output logic [COORD_WIDTH-1:0]           y_minus,
   output logic [bre_pkg::COLOR_BITS-1:0]   color
);
   import bre_pkg::*;

   localparam int RW     = RADIUS_WIDTH;
   localparam int XW     = RW + 1;
   localparam int YW     = RW + 2;
   localparam int SQ_W   = 2 * RW;
   localparam int PROD_W = 3 * RW + 4;
   localparam int ERR_W  = 3 * RW + 6;
   localparam int SUM_W  = (COORD_WIDTH > YW) ? COORD_WIDTH : YW;

   logic [XW-1:0]                x_ff, x_in;
   logic signed [YW-1:0]         y_ff, y_in;
   logic signed [ERR_W-1:0]      d_ff, d_in;
   logic signed [ERR_W-1:0]      ay_ff, ay_in;   // a^2 * (2y - 1)
   logic signed [ERR_W-1:0]      bx_ff, bx_in;   // b^2 * (2x + 1)
   logic [SQ_W-1:0]              a_sq_ff, a_sq_in;
   logic [SQ_W-1:0]              b_sq_ff, b_sq_in;
   logic [RW-1:0]                ra_ff, ra_in;
   logic                         rb_zero_ff, rb_zero_in;
   logic signed [COORD_WIDTH-1:0] cx_ff, cx_in;
   logic signed [COORD_WIDTH-1:0] cy_ff, cy_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;
   logic                         busy_ff, busy_in;

   logic signed [ERR_W-1:0]      pa_ext, pb_ext, two_pa, two_pb;
   logic signed [ERR_W-1:0]      bx_inc, ay_neg_dec, t_neg, t_pos;
   logic signed [SQ_W:0]         pa_s;
   logic signed [YW:0]           two_y_m1;
   logic signed [PROD_W-1:0]     ay_prod;
   logic                         mov_x, mov_y;
   logic [XW-1:0]                x_step;
   logic signed [YW-1:0]         y_step;
   logic                         flat_done;
   logic [SUM_W-1:0]             cx_w, cy_w, x_w, y_w;
   logic [SUM_W-1:0]             xp_sum, xm_sum, yp_sum, ym_sum;

   assign pa_ext = ERR_W'($signed({1'b0, a_sq_ff}));
   assign pb_ext = ERR_W'($signed({1'b0, b_sq_ff}));
   assign two_pa = pa_ext <<< 1;
   assign two_pb = pb_ext <<< 1;

   // Initial a^2 * (2 rb - 1); y already holds rb during the busy cycle.
   assign pa_s     = $signed({1'b0, a_sq_ff});
   assign two_y_m1 = ((YW+1)'(y_ff) <<< 1) - (YW+1)'(1);
   assign ay_prod  = pa_s * two_y_m1;

   // Error update: each move adds a term that depends only on the old
   // coordinates, so the two moves can be applied in any order.
   assign bx_inc     = bx_ff + two_pb;
   assign ay_neg_dec = two_pa - ay_ff;
   assign t_neg      = (d_ff <<< 1) + ay_ff;
   assign t_pos      = (d_ff <<< 1) - bx_ff;

   always_comb begin
      if (d_ff < 0) begin
         mov_x = 1'b1;
         mov_y = (t_neg > 0);
      end else if (d_ff == 0) begin
         mov_x = 1'b1;
         mov_y = 1'b1;
      end else begin
         mov_x = (t_pos < 0);
         mov_y = 1'b1;
      end
   end

   assign x_step = x_ff + XW'(mov_x);
   assign y_step = y_ff - YW'(mov_y);
   // With a zero vertical radius the error never lowers y; stop past ra.
   assign flat_done = rb_zero_ff && (x_step > {1'b0, ra_ff});

   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      d_in       = d_ff;
      ay_in      = ay_ff;
      bx_in      = bx_ff;
      a_sq_in    = a_sq_ff;
      b_sq_in    = b_sq_ff;
      ra_in      = ra_ff;
      rb_zero_in = rb_zero_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      color_in   = color_ff;
      busy_in    = 1'b0;
      if (start_load) begin
         a_sq_in    = radius_a * radius_a;
         b_sq_in    = radius_b * radius_b;
         ra_in      = radius_a;
         rb_zero_in = (radius_b == '0);
         cx_in      = center_x;
         cy_in      = center_y;
         color_in   = pixel_color;
         x_in       = '0;
         y_in       = YW'($signed({1'b0, radius_b}));
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         ay_in = ERR_W'(ay_prod);
         d_in  = pb_ext - ERR_W'(ay_prod) - two_pa;
         bx_in = pb_ext;
      end else if (step_load && !y_ff[YW-1]) begin
         x_in  = x_step;
         y_in  = (flat_done || y_step[YW-1]) ? -YW'(1) : y_step;
         d_in  = d_ff + (mov_x ? bx_inc : '0) + (mov_y ? ay_neg_dec : '0);
         bx_in = mov_x ? bx_inc : bx_ff;
         ay_in = mov_y ? (ay_ff - two_pa) : ay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= -YW'(1);
         d_ff    <= '0;
         busy_ff <= 1'b0;
      end else begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         d_ff    <= d_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      ay_ff      <= ay_in;
      bx_ff      <= bx_in;
      a_sq_ff    <= a_sq_in;
      b_sq_ff    <= b_sq_in;
      ra_ff      <= ra_in;
      rb_zero_ff <= rb_zero_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      color_ff   <= color_in;
   end

   // Mirrored coordinates of the current offset, wrapping at the coordinate width.
   assign cx_w   = SUM_W'(cx_ff);
   assign cy_w   = SUM_W'(cy_ff);
   assign x_w    = SUM_W'(x_ff);
   assign y_w    = SUM_W'(y_ff);
   assign xp_sum = cx_w + x_w;
   assign xm_sum = cx_w - x_w;
   assign yp_sum = cy_w + y_w;
   assign ym_sum = cy_w - y_w;

   assign x_plus  = xp_sum[COORD_WIDTH-1:0];
   assign x_minus = xm_sum[COORD_WIDTH-1:0];
   assign y_plus  = yp_sum[COORD_WIDTH-1:0];
   assign y_minus = ym_sum[COORD_WIDTH-1:0];
   assign color   = color_ff;

   assign status.busy   = busy_ff;
   assign status.active = !y_ff[YW-1];

   assign point_ctrl.pixel    = !y_ff[YW-1];
   assign point_ctrl.finished = y_ff[YW-1] || y_in[YW-1];

endmodule

// ===== rtl/core/bre_emit.sv =====
// ---------------------------------------------------------------------------
// Ellipse rasterizer result serializer
// Holds the four mirrored points of one step and sends them one transaction
// per cycle unless stalled; an idle step sends a single empty transaction.
// ---------------------------------------------------------------------------
module bre_emit #(
   parameter int COORD_WIDTH = bre_pkg::COORD_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    load,
   input  bre_pkg::bre_point_ctrl_type             point_ctrl,
   input  logic [COORD_WIDTH-1:0]                  x_plus,
   input  logic [COORD_WIDTH-1:0]                  x_minus,
   input  logic [COORD_WIDTH-1:0]                  y_plus,
   input  logic [COORD_WIDTH-1:0]                  y_minus,
   input  logic [bre_pkg::COLOR_BITS-1:0]          color,
   output logic                                    load_ready,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [COORD_WIDTH-1:0]                  rsp_point_x,
   output logic [COORD_WIDTH-1:0]                  rsp_point_y,
   output logic [bre_pkg::COLOR_BITS-1:0]          rsp_point_color,
   output logic [bre_pkg::RSP_USER_BITS-1:0]       rsp_tuser,
   output logic                                    rsp_tlast
);
   import bre_pkg::*;

   logic                   full_ff, full_in;
   logic [1:0]             beat_ff, beat_in;
   logic [COORD_WIDTH-1:0] xp_ff, xm_ff, yp_ff, ym_ff;
   logic [COLOR_BITS-1:0]  color_ff;
   bre_point_ctrl_type     ctrl_ff;
   logic                   take, last_beat;

   assign last_beat  = !ctrl_ff.pixel || (beat_ff == 2'd3);
   assign take       = full_ff && rsp_tready;
   assign load_ready = !full_ff || (take && last_beat);

   always_comb begin
      full_in = full_ff;
      beat_in = beat_ff;
      if (load) begin
         full_in = 1'b1;
         beat_in = '0;
      end else if (take) begin
         if (last_beat) begin
            full_in = 1'b0;
         end else begin
            beat_in = beat_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         beat_ff <= '0;
      end else begin
         full_ff <= full_in;
         beat_ff <= beat_in;
      end
   end

   // An idle step carries all-zero coordinates and color.
   always_ff @(posedge clock) begin
      if (load) begin
         ctrl_ff  <= point_ctrl;
         xp_ff    <= point_ctrl.pixel ? x_plus  : '0;
         xm_ff    <= point_ctrl.pixel ? x_minus : '0;
         yp_ff    <= point_ctrl.pixel ? y_plus  : '0;
         ym_ff    <= point_ctrl.pixel ? y_minus : '0;
         color_ff <= point_ctrl.pixel ? color   : '0;
      end
   end

   // Quadrant order: (+x,+y), (-x,+y), (+x,-y), (-x,-y).
   assign rsp_tvalid      = full_ff;
   assign rsp_point_x     = beat_ff[0] ? xm_ff : xp_ff;
   assign rsp_point_y     = beat_ff[1] ? ym_ff : yp_ff;
   assign rsp_point_color = color_ff;
   assign rsp_tlast       = last_beat;

   always_comb begin
      rsp_tuser                    = '0;
      rsp_tuser[RSP_USER_PIXEL]    = ctrl_ff.pixel;
      rsp_tuser[RSP_USER_FINISHED] = ctrl_ff.finished;
   end

endmodule

// ===== rtl/core/bresenham_ellipse_raster.sv =====
// ---------------------------------------------------------------------------
// Bresenham ellipse rasterizer
// Axis-aligned ellipse drawing with whole-pixel error terms, four mirrored
// pixels per step.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_*. req_tuser selects the kind: a start transaction
//   loads center, radii and color and returns nothing; a step transaction
//   returns the current offset mirrored into four quadrants and advances the
//   error term. A step with no drawing in progress returns one transaction
//   with the pixel flag low, zero data and tlast high.
//   Results leave on rsp_*, four transactions per step, tlast on the fourth.
//   The finished flag is set on every transaction of the step that ends the
//   drawing.
//   rsp_tvalid of a step's first result rises once the request has passed
//   the input register and been loaded into the result serializer. A step
//   holds the result port until its last result is taken, and the next step
//   can load as that happens. A start first forms the squares in the engine,
//   then the initial error product, and holds back a step that directly
//   follows it until the product is done.
//   An input register takes the next request while results are still being
//   sent. When rsp_tready is low, the held step waits and req_tready drops
//   once the input register is also occupied.
//   Reset clears the pipeline and leaves no drawing in progress.
// ---------------------------------------------------------------------------
module bresenham_ellipse_raster #(
   parameter int COORD_WIDTH  = bre_pkg::COORD_WIDTH_DEF,
   parameter int RADIUS_WIDTH = bre_pkg::RADIUS_WIDTH_DEF,
   localparam int REQ_BITS    = 2 * COORD_WIDTH + 2 * RADIUS_WIDTH + bre_pkg::COLOR_BITS,
   localparam int REQ_WIDTH   = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS    = 2 * COORD_WIDTH + bre_pkg::COLOR_BITS,
   localparam int RSP_WIDTH   = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // center_x, center_y, radius_a, radius_b, pixel_color
   input  logic [REQ_WIDTH-1:0]                 req_tdata,
   // op
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // point_x, point_y, point_color
   output logic [RSP_WIDTH-1:0]                 rsp_tdata,
   // point_valid, finished
   output logic [bre_pkg::RSP_USER_BITS-1:0]    rsp_tuser,
   // last_of_step
   output logic                                 rsp_tlast
);
   import bre_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int RW = RADIUS_WIDTH;
   localparam int OFS_CY = CW;
   localparam int OFS_RA = 2 * CW;
   localparam int OFS_RB = 2 * CW + RW;
   localparam int OFS_CO = 2 * CW + 2 * RW;

   logic                    in_valid_ff, in_valid_in;
   logic                    in_op_ff;
   logic signed [CW-1:0]    in_cx_ff, in_cy_ff;
   logic [RW-1:0]           in_ra_ff, in_rb_ff;
   logic [COLOR_BITS-1:0]   in_color_ff;

   logic                    accept, consume, start_load, step_load, emit_ready;
   bre_status_type          status;
   bre_point_ctrl_type      point_ctrl;
   logic [CW-1:0]           x_plus, x_minus, y_plus, y_minus;
   logic [COLOR_BITS-1:0]   color;
   logic [CW-1:0]           rsp_point_x, rsp_point_y;
   logic [COLOR_BITS-1:0]   rsp_point_color;

   assign consume    = in_valid_ff && !status.busy &&
                       ((in_op_ff == OP_START) || emit_ready);
   assign start_load = consume && (in_op_ff == OP_START);
   assign step_load  = consume && (in_op_ff == OP_STEP);
   assign req_tready = !in_valid_ff || consume;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff    <= req_tuser;
         in_cx_ff    <= req_tdata[CW-1:0];
         in_cy_ff    <= req_tdata[OFS_CY +: CW];
         in_ra_ff    <= req_tdata[OFS_RA +: RW];
         in_rb_ff    <= req_tdata[OFS_RB +: RW];
         in_color_ff <= req_tdata[OFS_CO +: COLOR_BITS];
      end
   end

   bre_engine #(
      .COORD_WIDTH  (COORD_WIDTH),
      .RADIUS_WIDTH (RADIUS_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start_load  (start_load),
      .step_load   (step_load),
      .center_x    (in_cx_ff),
      .center_y    (in_cy_ff),
      .radius_a    (in_ra_ff),
      .radius_b    (in_rb_ff),
      .pixel_color (in_color_ff),
      .status      (status),
      .point_ctrl  (point_ctrl),
      .x_plus      (x_plus),
      .x_minus     (x_minus),
      .y_plus      (y_plus),
      .y_minus     (y_minus),
      .color       (color)
   );

   bre_emit #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (step_load),
      .point_ctrl      (point_ctrl),
      .x_plus          (x_plus),
      .x_minus         (x_minus),
      .y_plus          (y_plus),
      .y_minus         (y_minus),
      .color           (color),
      .load_ready      (emit_ready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_color (rsp_point_color),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast)
   );

   assign rsp_tdata = RSP_WIDTH'({rsp_point_color, rsp_point_y, rsp_point_x});

   // A transaction without a pixel is always alone in its step.
   a_idle_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RSP_USER_PIXEL] |-> rsp_tlast)
      else $error("idle result without last_of_step");

   // An idle result carries no coordinates and no color.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RSP_USER_PIXEL] |-> rsp_tdata == '0)
      else $error("idle result with nonzero data");

   // A start always spends the following cycle on its initial product.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start_load |=> status.busy && !consume)
      else $error("start not followed by its initialization cycle");

   // A finished pixel step leaves no drawing in progress.
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      step_load && point_ctrl.pixel && point_ctrl.finished |=> !status.active)
      else $error("drawing still active after its final step");

endmodule
